@@ rtl/core/anxb_pkg.sv @@
// Shared widths, result kinds and the result record of the Annex B NAL splitter.
package anxb_pkg;

    localparam int POSITION_BITS   = 32;
    localparam int ZERO_COUNT_BITS = 16;
    localparam int FRAME_BITS      = 16;

    localparam int BYTE_W   = 8;
    localparam int ZEROS_W  = 16;
    localparam int TYPE_W   = 5;
    localparam int OFFSET_W = 32;
    localparam int FRAME_W  = 16;

    localparam int MAX_RESULTS = 3;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

    localparam logic [BYTE_W-1:0] START_BYTE = BYTE_W'(1);
    localparam logic [TYPE_W-1:0] TYPE_MASK  = TYPE_W'(5'h1f);
    localparam logic [TYPE_W-1:0] AUD_TYPE   = TYPE_W'(9);
    localparam int SHORT_CODE = 3;
    localparam int LONG_CODE  = 4;

    typedef enum logic [1:0] {
        KIND_BEGIN   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [BYTE_W-1:0]     payload_byte;
        logic [ZEROS_W-1:0]    zeros_before;
        logic                  zero_overflow;
        logic [TYPE_W-1:0]     nal_type;
        logic [OFFSET_W-1:0]   nal_offset;
        logic [FRAME_W-1:0]    frame_number;
    } t_result;

    typedef struct packed {
        logic                  load;
        logic [COUNT_W-1:0]    count;
    } t_load_ctrl;

endpackage

@@ rtl/core/anxb_result_queue.sv @@
// Result queue: holds the results of one transaction and hands them out in order.
module anxb_result_queue (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  anxb_pkg::t_load_ctrl                    i_load,
    input  anxb_pkg::t_result [anxb_pkg::MAX_RESULTS-1:0] i_results,
    output logic                                    o_can_load,
    output anxb_pkg::t_result                       o_head,
    output logic                                    o_valid,
    output logic                                    o_last,
    input  logic                                    i_ready
);

    anxb_pkg::t_result [anxb_pkg::MAX_RESULTS-1:0] r_slot;
    logic [anxb_pkg::COUNT_W-1:0]                  r_cnt;
    logic                                          pop;

    assign pop        = o_valid && i_ready;
    assign o_valid    = (r_cnt != '0);
    assign o_last     = (r_cnt == anxb_pkg::COUNT_W'(1));
    assign o_head     = r_slot[0];
    assign o_can_load = (r_cnt == '0) || (o_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load.load) begin
            r_cnt <= i_load.count;
        end else if (pop) begin
            r_cnt <= r_cnt - anxb_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_slot <= i_results;
        end else if (pop) begin
            for (int i = 0; i < anxb_pkg::MAX_RESULTS - 1; i++) begin
                r_slot[i] <= r_slot[i+1];
            end
        end
    end

endmodule

@@ rtl/core/annexb_nal_unit_splitter_core.sv @@
// Annex B byte stream splitter: start code search, NAL framing and zero run tracking.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | i_valid / o_ready  | i_data_byte, i_end_of_stream
//  result  | out       | o_valid / i_ready  | o_kind, o_payload_byte, o_zeros_before,
//          |           |                    | o_zero_overflow, o_nal_type, o_nal_offset,
//          |           |                    | o_frame_number, o_last
//
// A byte is parsed in the cycle it is accepted; its zero to three results appear
// from the next cycle, one per cycle while i_ready is high.
// One byte per cycle while each byte yields at most one result and i_ready is high; a byte
// with more results holds the input until its last result is taken at the single result port.
// Synchronous reset clears the parser state and drops queued results.
module annexb_nal_unit_splitter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [anxb_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic                                i_end_of_stream,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_kind,
    output logic [anxb_pkg::BYTE_W-1:0]         o_payload_byte,
    output logic [anxb_pkg::ZEROS_W-1:0]        o_zeros_before,
    output logic                                o_zero_overflow,
    output logic [anxb_pkg::TYPE_W-1:0]         o_nal_type,
    output logic [anxb_pkg::OFFSET_W-1:0]       o_nal_offset,
    output logic [anxb_pkg::FRAME_W-1:0]        o_frame_number,
    output logic                                o_last
);

    localparam int PB = anxb_pkg::POSITION_BITS;
    localparam int ZB = anxb_pkg::ZERO_COUNT_BITS;
    localparam int FB = anxb_pkg::FRAME_BITS;

    logic [PB-1:0] r_pos,  n_pos;
    logic [ZB-1:0] r_zrun, n_zrun;
    logic          r_zsat, n_zsat;
    logic          r_after, n_after;
    logic          r_open, n_open;
    logic [PB-1:0] r_start, n_start;
    logic [FB-1:0] r_frame, n_frame;
    logic          r_seen, n_seen;

    logic          accept;
    logic          can_load;
    logic          is_zero, ge_short, ge_long, start_code;
    logic          has_end1, has_begin, has_pay, has_end2, open_mid;
    logic [anxb_pkg::TYPE_W-1:0] nal_ty;
    logic [FB-1:0] frame_upd;
    logic [PB-1:0] sc_offset;

    anxb_pkg::t_result [anxb_pkg::MAX_RESULTS-1:0] res;
    anxb_pkg::t_load_ctrl                          ld;
    anxb_pkg::t_result                             head;

    assign accept  = i_valid && can_load;
    assign o_ready = can_load;

    assign is_zero    = (i_data_byte == '0);
    assign ge_short   = (r_zrun >= ZB'(anxb_pkg::SHORT_CODE - 1));
    assign ge_long    = (r_zrun >= ZB'(anxb_pkg::LONG_CODE - 1));
    assign start_code = (i_data_byte == anxb_pkg::START_BYTE) && ge_short
                        && (!i_end_of_stream || ge_long);
    assign sc_offset  = ge_long ? (r_pos - PB'(anxb_pkg::LONG_CODE - 1))
                                : (r_pos - PB'(anxb_pkg::SHORT_CODE - 1));

    assign has_end1  = start_code && r_open;
    assign has_pay   = !is_zero && !start_code && r_after;
    assign has_begin = has_pay && !r_open;
    assign open_mid  = start_code ? 1'b0 : (has_pay ? 1'b1 : r_open);
    assign has_end2  = i_end_of_stream && open_mid;

    assign nal_ty    = (r_zrun != '0) ? '0 : (i_data_byte[anxb_pkg::TYPE_W-1:0]
                                              & anxb_pkg::TYPE_MASK);
    assign frame_upd = (r_seen && nal_ty == anxb_pkg::AUD_TYPE)
                       ? r_frame + FB'(1) : r_frame;

    always_comb begin
        logic [anxb_pkg::COUNT_W-1:0] k;
        anxb_pkg::t_result            r_beg, r_pay, r_end;
        k = '0;
        r_beg = '0;
        r_beg.kind = anxb_pkg::KIND_BEGIN;
        r_beg.nal_type = nal_ty;
        r_beg.nal_offset = anxb_pkg::OFFSET_W'(r_start);
        r_beg.frame_number = anxb_pkg::FRAME_W'(frame_upd);
        r_pay = '0;
        r_pay.kind = anxb_pkg::KIND_PAYLOAD;
        r_pay.payload_byte = i_data_byte;
        r_pay.zeros_before = anxb_pkg::ZEROS_W'(r_zrun);
        r_pay.zero_overflow = r_zsat;
        r_end = '0;
        r_end.kind = anxb_pkg::KIND_END;
        res = '0;
        if (has_end1) begin
            res[k[1:0]] = r_end;
            k = k + anxb_pkg::COUNT_W'(1);
        end
        if (has_begin) begin
            res[k[1:0]] = r_beg;
            k = k + anxb_pkg::COUNT_W'(1);
        end
        if (has_pay) begin
            res[k[1:0]] = r_pay;
            k = k + anxb_pkg::COUNT_W'(1);
        end
        if (has_end2) begin
            res[k[1:0]] = r_end;
            k = k + anxb_pkg::COUNT_W'(1);
        end
        ld.load  = accept;
        ld.count = k;
    end

    always_comb begin
        n_pos   = r_pos + PB'(1);
        n_zrun  = r_zrun;
        n_zsat  = r_zsat;
        n_after = r_after;
        n_open  = open_mid;
        n_start = r_start;
        n_frame = r_frame;
        n_seen  = r_seen;
        if (is_zero) begin
            if (r_zrun == '1) begin
                n_zsat = 1'b1;
            end else begin
                n_zrun = r_zrun + ZB'(1);
            end
        end else begin
            n_zrun = '0;
            n_zsat = 1'b0;
        end
        if (start_code) begin
            n_after = 1'b1;
            n_start = sc_offset;
        end
        if (has_begin) begin
            n_seen  = 1'b1;
            n_frame = frame_upd;
        end
        if (i_end_of_stream) begin
            n_pos   = '0;
            n_zrun  = '0;
            n_zsat  = 1'b0;
            n_after = 1'b0;
            n_open  = 1'b0;
            n_start = '0;
            n_frame = '0;
            n_seen  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_zrun  <= '0;
            r_zsat  <= 1'b0;
            r_after <= 1'b0;
            r_open  <= 1'b0;
            r_start <= '0;
            r_frame <= '0;
            r_seen  <= 1'b0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_zrun  <= n_zrun;
            r_zsat  <= n_zsat;
            r_after <= n_after;
            r_open  <= n_open;
            r_start <= n_start;
            r_frame <= n_frame;
            r_seen  <= n_seen;
        end
    end

    anxb_result_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (ld),
        .i_results  (res),
        .o_can_load (can_load),
        .o_head     (head),
        .o_valid    (o_valid),
        .o_last     (o_last),
        .i_ready    (i_ready)
    );

    assign o_kind          = (o_valid ? head.kind : anxb_pkg::KIND_BEGIN);
    assign o_payload_byte  = head.payload_byte;
    assign o_zeros_before  = head.zeros_before;
    assign o_zero_overflow = head.zero_overflow;
    assign o_nal_type      = head.nal_type;
    assign o_nal_offset    = head.nal_offset;
    assign o_frame_number  = head.frame_number;

endmodule
